// File: rtl/qenc_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature encoder counter package
// Shared constants, operation codes, register indexes and the controller to
// datapath command and status types.
// ----------------------------------------------------------------------------
package qenc_pkg;

    // Default step counter width.
    localparam int STEP_BITS_DEF = 24;

    // Register reset values.
    localparam logic [15:0] SPR_RESET = 16'd30;
    localparam logic [9:0]  DEB_RESET = 10'd50;

    // Degrees in one full turn.
    localparam logic signed [9:0] DEG_FULL = 10'sd360;

    // Width of the divisor (steps per revolution).
    localparam int SPR_W = 16;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_PIN   = 2'd0;
    localparam logic [1:0] OP_BTN   = 2'd1;
    localparam logic [1:0] OP_RPOS  = 2'd2;
    localparam logic [1:0] OP_POLL  = 2'd3;

    // Register index, taken from address bit 2.
    localparam logic REG_SPR = 1'b0;
    localparam logic REG_DEB = 1'b1;

    // Pin transition table, indexed by {old_a, old_b, new_a, new_b}.
    localparam logic signed [1:0] QUAD_TABLE [16] = '{
        2'sd0, -2'sd1,  2'sd1,  2'sd0,
        2'sd1,  2'sd0,  2'sd0, -2'sd1,
       -2'sd1,  2'sd0,  2'sd0,  2'sd1,
        2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the input transaction
        logic exec;       // apply the operation to the state
        logic mult;       // form steps * 360
        logic div_start;  // launch the divider
        logic load_out;   // load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/quadrature_encoder_counter_core.sv
// ----------------------------------------------------------------------------
// Quadrature encoder counter core
// Decodes a two-phase encoder into a saturating step count, tracks a
// debounced push button and reports the shaft angle in degrees.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                   Direction
//   -------   ---------------------------------------   ---------
//   input     i_valid/o_ready, i_opcode, i_phase_a,     in
//             i_phase_b, i_now_ms
//   result    o_valid/i_ready, o_step_count,            out
//             o_angle_deg, o_button_flag
//   config    psel, penable, pwrite, paddr, pwdata,     in/out
//             prdata, pready
//
// An input transaction is accepted only while the controller is idle, so a new
// one waits until the previous result has been loaded into the output register.
// The restoring divider produces one quotient bit of the angle per cycle
// over the STEP_BITS + 9 bit numerator; update and multiply run in their own
// states ahead of the division, and the result is loaded into the output
// register once the quotient is ready and the register is free.
// Reset is synchronous and active low. It returns the step count to half the
// default revolution, the pin state to both phases high, and the registers
// to 30 steps per turn and 50 ms debounce.
// A result that the sink does not take waits in the output register; the
// input side is accepting again meanwhile and the next result waits for the
// register to be emptied. Configuration writes complete without wait states and
// must only be issued while no transaction is in flight.
//
// Datapath overview: the controller captures a transaction, then has the
// datapath apply it (pin decode through the transition table, button
// debounce, reposition or poll), multiply the step count by 360, and run the
// divider against steps per revolution. A zero steps per revolution gives an
// angle of zero. The quotient truncates towards zero, as the sign is taken
// off before division and put back afterwards.
// ----------------------------------------------------------------------------
module quadrature_encoder_counter_core #(
    parameter int STEP_BITS = qenc_pkg::STEP_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_opcode,
    input  logic                        i_phase_a,
    input  logic                        i_phase_b,
    input  logic [31:0]                 i_now_ms,

    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [STEP_BITS-1:0] o_step_count,
    output logic signed [STEP_BITS+8:0] o_angle_deg,
    output logic                        o_button_flag,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    qenc_pkg::t_cmd cmd;
    qenc_pkg::t_sts sts;
    logic [15:0]    spr;
    logic [9:0]     deb;

    // The register file never inserts wait states.
    assign pready = 1'b1;

    qenc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_spr   (spr),
        .o_deb   (deb)
    );

    qenc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    qenc_dp #(
        .STEP_BITS(STEP_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_opcode),
        .i_phase_a     (i_phase_a),
        .i_phase_b     (i_phase_b),
        .i_now_ms      (i_now_ms),
        .i_spr         (spr),
        .i_deb         (deb),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_step_count  (o_step_count),
        .o_angle_deg   (o_angle_deg),
        .o_button_flag (o_button_flag)
    );

endmodule

// File: rtl/qenc_regs.sv
// ----------------------------------------------------------------------------
// Quadrature encoder configuration registers
// APB-style register file holding steps per revolution and debounce time.
// ----------------------------------------------------------------------------
module qenc_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic [15:0] o_spr,
    output logic [9:0]  o_deb
);

    logic [15:0] r_spr;
    logic [9:0]  r_deb;
    logic        wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spr <= qenc_pkg::SPR_RESET;
            r_deb <= qenc_pkg::DEB_RESET;
        end else if (wr_en) begin
            if (paddr[2] == qenc_pkg::REG_SPR) begin
                r_spr <= pwdata[15:0];
            end else begin
                r_deb <= pwdata[9:0];
            end
        end
    end

    // The low address bits are don't-care.
    assign prdata = (paddr[2] == qenc_pkg::REG_DEB) ? {22'd0, r_deb} : {16'd0, r_spr};
    assign o_spr  = r_spr;
    assign o_deb  = r_deb;

endmodule

// File: rtl/qenc_div.sv
// ----------------------------------------------------------------------------
// Quadrature encoder angle divider
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module qenc_div #(
    parameter int W = qenc_pkg::STEP_BITS_DEF + 9
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [W-1:0]                i_dividend,
    input  logic [qenc_pkg::SPR_W-1:0]         i_divisor,
    output logic                               o_done,
    output logic signed [W-1:0]                o_quot
);

    localparam int CNT_W = $clog2(W + 1);
    localparam int DV_W  = qenc_pkg::SPR_W;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DV_W-1:0]  r_rem;
    logic [W-1:0]     r_quo;
    logic             r_neg;
    logic             r_zero;

    logic [W-1:0]     mag;
    logic [DV_W:0]    rem_sh;
    logic [DV_W+1:0]  diff;

    assign mag    = i_dividend[W-1] ? W'(-i_dividend) : W'(i_dividend);
    assign rem_sh = {r_rem, r_quo[W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= mag;
            r_neg  <= i_dividend[W-1];
            r_zero <= (i_divisor == '0);
        end else if (r_busy && (r_cnt != '0)) begin
            // The dividend shifts out at the top as quotient bits shift in.
            if (diff[DV_W+1]) begin
                r_rem <= rem_sh[DV_W-1:0];
            end else begin
                r_rem <= diff[DV_W-1:0];
            end
            r_quo <= {r_quo[W-2:0], ~diff[DV_W+1]};
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_zero ? '0 : (r_neg ? W'(-$signed(r_quo)) : $signed(r_quo));

endmodule

// File: rtl/qenc_dp.sv
// ----------------------------------------------------------------------------
// Quadrature encoder datapath
// Encoder and button state, angle multiply, divider and output register.
// ----------------------------------------------------------------------------
module qenc_dp #(
    parameter int STEP_BITS = qenc_pkg::STEP_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  qenc_pkg::t_cmd              i_cmd,
    output qenc_pkg::t_sts              o_sts,
    input  logic [1:0]                  i_opcode,
    input  logic                        i_phase_a,
    input  logic                        i_phase_b,
    input  logic [31:0]                 i_now_ms,
    input  logic [15:0]                 i_spr,
    input  logic [9:0]                  i_deb,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic signed [STEP_BITS-1:0] o_step_count,
    output logic signed [STEP_BITS+8:0] o_angle_deg,
    output logic                        o_button_flag
);

    localparam int PROD_W = STEP_BITS + 9;
    localparam logic signed [STEP_BITS-1:0] STEP_MAX = {1'b0, {(STEP_BITS-1){1'b1}}};
    localparam logic signed [STEP_BITS-1:0] STEP_MIN = {1'b1, {(STEP_BITS-1){1'b0}}};
    localparam logic signed [STEP_BITS-1:0] STEP_RST = STEP_BITS'(qenc_pkg::SPR_RESET / 2);

    // Captured transaction.
    logic [1:0]  r_opcode;
    logic [1:0]  r_pins;
    logic [31:0] r_now;

    // Block state.
    logic signed [STEP_BITS-1:0] r_step;
    logic signed [1:0]           r_psum;
    logic [1:0]                  r_last;
    logic                        r_latch;
    logic [31:0]                 r_last_ms;
    logic                        r_flag;

    logic signed [STEP_BITS-1:0] n_step;
    logic signed [1:0]           n_psum;
    logic [1:0]                  n_last;
    logic                        n_latch;
    logic [31:0]                 n_last_ms;
    logic                        n_flag;

    logic signed [1:0]           delta;
    logic signed [2:0]           sum;
    logic [31:0]                 elapsed;
    logic [32:0]                 half_w;

    logic signed [STEP_BITS+9:0] prod_full;
    logic signed [PROD_W-1:0]    r_prod;
    logic                        div_done;
    logic signed [PROD_W-1:0]    quot;

    logic                        r_out_valid;
    logic signed [STEP_BITS-1:0] r_out_step;
    logic signed [PROD_W-1:0]    r_out_angle;
    logic                        r_out_flag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_opcode <= i_opcode;
            r_pins   <= {i_phase_a, i_phase_b};
            r_now    <= i_now_ms;
        end
    end

    assign delta   = qenc_pkg::QUAD_TABLE[{r_last, r_pins}];
    assign sum     = r_psum + delta;
    assign elapsed = r_now - r_last_ms;
    assign half_w  = {18'd0, i_spr[15:1]};

    always_comb begin
        n_step    = r_step;
        n_psum    = r_psum;
        n_last    = r_last;
        n_latch   = r_latch;
        n_last_ms = r_last_ms;
        n_flag    = r_latch;
        unique case (r_opcode)
            qenc_pkg::OP_PIN: begin
                n_last = r_pins;
                if (sum >= 3'sd2) begin
                    n_step = (r_step == STEP_MAX) ? r_step : r_step + STEP_BITS'(1);
                    n_psum = 2'sd0;
                end else if (sum <= -3'sd2) begin
                    n_step = (r_step == STEP_MIN) ? r_step : r_step - STEP_BITS'(1);
                    n_psum = 2'sd0;
                end else begin
                    n_psum = sum[1:0];
                end
            end
            qenc_pkg::OP_BTN: begin
                if (elapsed > {22'd0, i_deb}) begin
                    n_latch   = 1'b1;
                    n_last_ms = r_now;
                    n_flag    = 1'b1;
                end
            end
            qenc_pkg::OP_RPOS: begin
                n_step = (half_w > 33'(STEP_MAX)) ? STEP_MAX : STEP_BITS'(half_w);
            end
            qenc_pkg::OP_POLL: begin
                n_latch = 1'b0;
            end
            default: begin
                n_flag = r_latch;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= STEP_RST;
            r_psum    <= 2'sd0;
            r_last    <= 2'b11;
            r_latch   <= 1'b0;
            r_last_ms <= '0;
        end else if (i_cmd.exec) begin
            r_step    <= n_step;
            r_psum    <= n_psum;
            r_last    <= n_last;
            r_latch   <= n_latch;
            r_last_ms <= n_last_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_flag <= n_flag;
        end
    end

    // Angle numerator; 360 times the step count always fits in PROD_W bits.
    assign prod_full = r_step * qenc_pkg::DEG_FULL;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_prod <= prod_full[PROD_W-1:0];
        end
    end

    qenc_div #(
        .W(PROD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (i_spr),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Output register: a finished result waits here for the sink.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_step  <= r_step;
            r_out_angle <= quot;
            r_out_flag  <= r_flag;
        end
    end

    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_ready;

    assign o_valid       = r_out_valid;
    assign o_step_count  = r_out_step;
    assign o_angle_deg   = r_out_angle;
    assign o_button_flag = r_out_flag;

    // The accumulator only ever rests at -1, 0 or +1 between transactions.
    a_psum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_psum != -2'sd2)
        else $error("partial sum reached -2 while idle");

endmodule

// File: rtl/qenc_ctrl.sv
// ----------------------------------------------------------------------------
// Quadrature encoder controller
// Sequences capture, update, multiply, division and result hand-over.
// ----------------------------------------------------------------------------
module qenc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  qenc_pkg::t_sts i_sts,
    output qenc_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_MULT   = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DWAIT  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Nothing is taken while reset is held.
    assign o_ready = i_rst_n && (r_state == S_IDLE);

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.exec, o_cmd.mult, o_cmd.div_start, o_cmd.load_out}))
        else $error("more than one datapath command in a cycle");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("output register overwritten while a result waits");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DWAIT && !i_sts.div_done) |=> (r_state == S_DWAIT))
        else $error("left the divider wait before the quotient was ready");

endmodule
